FILE: design/trapezoid_motion_profile_core_macros.svh
// Assertion macros shared by the checker.
`ifndef TRAPEZOID_MOTION_PROFILE_CORE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_CORE_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define TMPG_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define TMPG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/tmpg_pkg.sv
`timescale 1ns / 1ps
package tmpg_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_PLAN   = 2'd1;
   localparam logic [1:0] ACT_SETPOS = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic CSR_MAX_VELOCITY     = 1'b0;
   localparam logic CSR_MAX_ACCELERATION = 1'b1;

   typedef enum logic [1:0] {
      PH_ACCEL,
      PH_CRUISE,
      PH_DECEL
   } phase_type;

   typedef enum logic [5:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SETPOS,
      CMD_TICK_TIME,
      CMD_STOP_GOAL,
      CMD_STOP_START,
      CMD_TAU,
      CMD_MA,
      CMD_MB,
      CMD_PA_LO,
      CMD_PA_HI,
      CMD_PA_SUM,
      CMD_Q_LO,
      CMD_Q_HI,
      CMD_Q_SUM,
      CMD_CV,
      CMD_TV,
      CMD_S1,
      CMD_S2,
      CMD_S3,
      CMD_FIN,
      CMD_PLAN_INIT,
      CMD_PLAN_ZERO,
      CMD_VV,
      CMD_DIV_DMIN,
      CMD_DMIN_TAKE,
      CMD_DIV_CRUISE,
      CMD_CRUISE_TAKE,
      CMD_DA,
      CMD_SQ_START,
      CMD_SQ_TAKE,
      CMD_DIV_ACCEL,
      CMD_ACCEL_TAKE,
      CMD_PLAN_END,
      CMD_EMIT
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SETPOS,
      ST_T_TIME,
      ST_T_DECIDE,
      ST_T_MA,
      ST_T_MB,
      ST_T_PLO,
      ST_T_PHI,
      ST_T_PSUM,
      ST_T_QLO,
      ST_T_QHI,
      ST_T_QSUM,
      ST_T_CV,
      ST_T_TV,
      ST_T_S1,
      ST_T_S2,
      ST_T_S3,
      ST_T_FIN,
      ST_P_INIT,
      ST_P_CHECK,
      ST_P_DMIN,
      ST_P_DMIN_W,
      ST_P_BRANCH,
      ST_P_CR_W,
      ST_P_SQ,
      ST_P_SQ_W,
      ST_P_ACC,
      ST_P_ACC_W,
      ST_P_TOTAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic tt_zero;
      logic el_ge_tt;
      logic el_zero;
      logic d_zero;
      logic d_ge_dmin;
      logic div_busy;
      logic sqrt_busy;
   } status_type;

endpackage

FILE: design/tmpg_div.sv
`timescale 1ns / 1ps
module tmpg_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [30:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [30:0] div_ff, div_in;
   logic [31:0] r2;
   logic        ge;

   always_comb begin
      r2      = {rem_ff, quo_ff[63]};
      ge      = r2 >= {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 31'(r2 - {1'b0, div_ff}) : r2[30:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

FILE: design/tmpg_sqrt.sv
`timescale 1ns / 1ps
module tmpg_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);
   logic        busy_ff, busy_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] sum;

   always_comb begin
      sum     = r_ff + bit_ff;
      busy_in = busy_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = radicand;
         r_in    = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (v_ff >= sum) begin
            v_in = v_ff - sum;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[31:0];
endmodule

FILE: design/tmpg_ctrl.sv
`timescale 1ns / 1ps
module tmpg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_action,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tmpg_pkg::status_type status,
   output tmpg_pkg::cmd_type    cmd
);
   import tmpg_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd = CMD_LOAD;
               case (req_action)
                  ACT_TICK:   state_in = ST_T_TIME;
                  ACT_PLAN:   state_in = ST_P_INIT;
                  ACT_SETPOS: state_in = ST_SETPOS;
                  default:    state_in = ST_EMIT;
               endcase
            end
         end
         ST_SETPOS: begin
            cmd      = CMD_SETPOS;
            state_in = ST_EMIT;
         end
         ST_T_TIME: begin
            cmd      = CMD_TICK_TIME;
            state_in = ST_T_DECIDE;
         end
         ST_T_DECIDE: begin
            if (status.tt_zero || status.el_ge_tt) begin
               cmd      = CMD_STOP_GOAL;
               state_in = ST_EMIT;
            end else if (status.el_zero) begin
               cmd      = CMD_STOP_START;
               state_in = ST_EMIT;
            end else begin
               cmd      = CMD_TAU;
               state_in = ST_T_MA;
            end
         end
         ST_T_MA:   begin cmd = CMD_MA;     state_in = ST_T_MB;   end
         ST_T_MB:   begin cmd = CMD_MB;     state_in = ST_T_PLO;  end
         ST_T_PLO:  begin cmd = CMD_PA_LO;  state_in = ST_T_PHI;  end
         ST_T_PHI:  begin cmd = CMD_PA_HI;  state_in = ST_T_PSUM; end
         ST_T_PSUM: begin cmd = CMD_PA_SUM; state_in = ST_T_QLO;  end
         ST_T_QLO:  begin cmd = CMD_Q_LO;   state_in = ST_T_QHI;  end
         ST_T_QHI:  begin cmd = CMD_Q_HI;   state_in = ST_T_QSUM; end
         ST_T_QSUM: begin cmd = CMD_Q_SUM;  state_in = ST_T_CV;   end
         ST_T_CV:   begin cmd = CMD_CV;     state_in = ST_T_TV;   end
         ST_T_TV:   begin cmd = CMD_TV;     state_in = ST_T_S1;   end
         ST_T_S1:   begin cmd = CMD_S1;     state_in = ST_T_S2;   end
         ST_T_S2:   begin cmd = CMD_S2;     state_in = ST_T_S3;   end
         ST_T_S3:   begin cmd = CMD_S3;     state_in = ST_T_FIN;  end
         ST_T_FIN:  begin cmd = CMD_FIN;    state_in = ST_EMIT;   end
         ST_P_INIT: begin
            cmd      = CMD_PLAN_INIT;
            state_in = ST_P_CHECK;
         end
         ST_P_CHECK: begin
            if (status.d_zero) begin
               cmd      = CMD_PLAN_ZERO;
               state_in = ST_EMIT;
            end else begin
               cmd      = CMD_VV;
               state_in = ST_P_DMIN;
            end
         end
         ST_P_DMIN: begin
            cmd      = CMD_DIV_DMIN;
            state_in = ST_P_DMIN_W;
         end
         ST_P_DMIN_W: begin
            if (!status.div_busy) begin
               cmd      = CMD_DMIN_TAKE;
               state_in = ST_P_BRANCH;
            end
         end
         ST_P_BRANCH: begin
            if (status.d_ge_dmin) begin
               cmd      = CMD_DIV_CRUISE;
               state_in = ST_P_CR_W;
            end else begin
               cmd      = CMD_DA;
               state_in = ST_P_SQ;
            end
         end
         ST_P_CR_W: begin
            if (!status.div_busy) begin
               cmd      = CMD_CRUISE_TAKE;
               state_in = ST_P_ACC;
            end
         end
         ST_P_SQ: begin
            cmd      = CMD_SQ_START;
            state_in = ST_P_SQ_W;
         end
         ST_P_SQ_W: begin
            if (!status.sqrt_busy) begin
               cmd      = CMD_SQ_TAKE;
               state_in = ST_P_ACC;
            end
         end
         ST_P_ACC: begin
            cmd      = CMD_DIV_ACCEL;
            state_in = ST_P_ACC_W;
         end
         ST_P_ACC_W: begin
            if (!status.div_busy) begin
               cmd      = CMD_ACCEL_TAKE;
               state_in = ST_P_TOTAL;
            end
         end
         ST_P_TOTAL: begin
            cmd      = CMD_PLAN_END;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd      = CMD_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd == CMD_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: design/tmpg_datapath.sv
`timescale 1ns / 1ps
module tmpg_datapath #(
   parameter int FRAC_BITS = tmpg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmpg_pkg::cmd_type    cmd,
   output tmpg_pkg::status_type status,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [30:0]          csr_wdata,
   input  logic [31:0]          target_position,
   input  logic [31:0]          new_position,
   input  logic [15:0]          time_step,
   output logic [95:0]          rsp_data
);
   import tmpg_pkg::*;

   localparam int SHIFT = 2 * FRAC_BITS + 1;
   localparam int STEP_SHIFT = 40 - FRAC_BITS;

   logic [30:0] vmax_ff, amax_ff;
   logic [31:0] tgt_ff, npos_ff;
   logic [15:0] step_ff;
   logic [31:0] start_ff, goal_ff;
   logic        neg_ff;
   logic [31:0] ta_ff, cr_ff, vp_ff, el_ff;
   logic [32:0] tt_ff;
   logic [31:0] pos_ff, vel_ff, acc_ff;
   phase_type   phase_ff;
   logic [31:0] tau_ff;
   logic [62:0] ma_ff, mb_ff, hi_ff;
   logic [63:0] lo_ff, pacc_ff, q_ff, cv_ff, tv_ff, s_ff, num_ff, dmin_ff;
   logic [31:0] p_ff;
   logic [95:0] rsp_ff;

   logic [30:0] a, v;
   logic [31:0] d, dts;
   logic [32:0] el_sum, tc;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic        div_start, sq_start, div_busy, sq_busy;
   logic [63:0] div_dividend, quotient;
   logic [30:0] div_divisor;
   logic [31:0] root;
   logic [33:0] total_sum;
   logic [63:0] psel, vsel, dv;
   logic [30:0] vcl;

   function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] mul_comb(input logic [63:0] lo, input logic [62:0] hi);
      logic [95:0] full, sh;
      full = {32'b0, lo} + {1'b0, hi, 32'b0};
      sh   = full >> SHIFT;
      return (sh[95:64] != '0) ? '1 : sh[63:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [63:0] x);
      return (x[63:32] != '0) ? '1 : x[31:0];
   endfunction

   assign a      = (amax_ff == '0) ? 31'd1 : amax_ff;
   assign v      = (vmax_ff == '0) ? 31'd1 : vmax_ff;
   assign d      = neg_ff ? (start_ff - goal_ff) : (goal_ff - start_ff);
   assign dts    = 32'((40'(step_ff) << 24) >> STEP_SHIFT);
   assign el_sum = {1'b0, el_ff} + {1'b0, dts};
   assign tc     = {1'b0, ta_ff} + {1'b0, cr_ff};
   assign total_sum = {1'b0, ta_ff, 1'b0} + {2'b0, cr_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd)
         CMD_MA:    begin mul_a = {1'b0, a};            mul_b = ta_ff;  end
         CMD_MB:    begin mul_a = {1'b0, a};            mul_b = tau_ff; end
         CMD_PA_LO: begin mul_a = ma_ff[31:0];          mul_b = ta_ff;  end
         CMD_PA_HI: begin mul_a = {1'b0, ma_ff[62:32]}; mul_b = ta_ff;  end
         CMD_Q_LO:  begin mul_a = mb_ff[31:0];          mul_b = tau_ff; end
         CMD_Q_HI:  begin mul_a = {1'b0, mb_ff[62:32]}; mul_b = tau_ff; end
         CMD_CV:    begin mul_a = vp_ff;                mul_b = cr_ff;  end
         CMD_TV:    begin mul_a = vp_ff;                mul_b = tau_ff; end
         CMD_VV:    begin mul_a = {1'b0, v};            mul_b = {1'b0, v}; end
         CMD_DA:    begin mul_a = d;                    mul_b = {1'b0, a}; end
         default:   begin mul_a = '0;                   mul_b = '0;     end
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = a;
      case (cmd)
         CMD_DIV_DMIN: begin
            div_start    = 1'b1;
            div_dividend = num_ff;
         end
         CMD_DIV_CRUISE: begin
            div_start    = 1'b1;
            div_dividend = (64'(d) - dmin_ff) << FRAC_BITS;
            div_divisor  = v;
         end
         CMD_DIV_ACCEL: begin
            div_start    = 1'b1;
            div_dividend = 64'(vp_ff) << FRAC_BITS;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   assign sq_start = (cmd == CMD_SQ_START);

   tmpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   tmpg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (num_ff),
      .busy     (sq_busy),
      .root     (root)
   );

   always_comb begin
      case (phase_ff)
         PH_ACCEL:  psel = q_ff;
         PH_CRUISE: psel = s_ff;
         default:   psel = (q_ff > s_ff) ? 64'd0 : (s_ff - q_ff);
      endcase
      dv = 64'(mb_ff >> FRAC_BITS);
      case (phase_ff)
         PH_ACCEL:  vsel = dv;
         PH_CRUISE: vsel = 64'(vp_ff);
         default:   vsel = (dv > 64'(vp_ff)) ? 64'd0 : (64'(vp_ff) - dv);
      endcase
      vcl = (vsel > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : vsel[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vmax_ff  <= 31'(1 << FRAC_BITS);
         amax_ff  <= 31'(1 << FRAC_BITS);
         start_ff <= '0;
         goal_ff  <= '0;
         neg_ff   <= 1'b0;
         ta_ff    <= '0;
         cr_ff    <= '0;
         tt_ff    <= '0;
         vp_ff    <= '0;
         el_ff    <= '0;
         pos_ff   <= '0;
         vel_ff   <= '0;
         acc_ff   <= '0;
         phase_ff <= PH_ACCEL;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_MAX_VELOCITY) begin
               vmax_ff <= csr_wdata;
            end else begin
               amax_ff <= csr_wdata;
            end
         end
         case (cmd)
            CMD_SETPOS: begin
               start_ff <= npos_ff;
               goal_ff  <= npos_ff;
               neg_ff   <= 1'b0;
               ta_ff    <= '0;
               cr_ff    <= '0;
               tt_ff    <= '0;
               vp_ff    <= '0;
               el_ff    <= '0;
               pos_ff   <= npos_ff;
               vel_ff   <= '0;
               acc_ff   <= '0;
            end
            CMD_TICK_TIME: begin
               el_ff <= el_sum[32] ? '1 : el_sum[31:0];
            end
            CMD_STOP_GOAL: begin
               pos_ff <= goal_ff;
               vel_ff <= '0;
               acc_ff <= '0;
            end
            CMD_STOP_START: begin
               pos_ff <= start_ff;
               vel_ff <= '0;
               acc_ff <= '0;
            end
            CMD_TAU: begin
               if (el_ff < ta_ff) begin
                  phase_ff <= PH_ACCEL;
               end else if ({1'b0, el_ff} < tc) begin
                  phase_ff <= PH_CRUISE;
               end else begin
                  phase_ff <= PH_DECEL;
               end
            end
            CMD_FIN: begin
               if (neg_ff) begin
                  pos_ff <= start_ff - p_ff;
                  vel_ff <= 32'(-$signed({1'b0, vcl}));
                  acc_ff <= (phase_ff == PH_ACCEL) ? 32'(-$signed({1'b0, a})) :
                            (phase_ff == PH_CRUISE) ? 32'd0 : {1'b0, a};
               end else begin
                  pos_ff <= start_ff + p_ff;
                  vel_ff <= {1'b0, vcl};
                  acc_ff <= (phase_ff == PH_ACCEL) ? {1'b0, a} :
                            (phase_ff == PH_CRUISE) ? 32'd0 : 32'(-$signed({1'b0, a}));
               end
            end
            CMD_PLAN_INIT: begin
               start_ff <= pos_ff;
               goal_ff  <= tgt_ff;
               el_ff    <= '0;
               neg_ff   <= $signed(tgt_ff) < $signed(pos_ff);
            end
            CMD_PLAN_ZERO: begin
               ta_ff  <= '0;
               cr_ff  <= '0;
               tt_ff  <= '0;
               vp_ff  <= '0;
               pos_ff <= goal_ff;
               vel_ff <= '0;
               acc_ff <= '0;
            end
            CMD_DIV_CRUISE: begin
               vp_ff <= {1'b0, v};
            end
            CMD_CRUISE_TAKE: begin
               cr_ff <= sat32(quotient);
            end
            CMD_SQ_TAKE: begin
               vp_ff <= root;
               cr_ff <= '0;
            end
            CMD_ACCEL_TAKE: begin
               ta_ff <= sat32(quotient);
            end
            CMD_PLAN_END: begin
               tt_ff  <= total_sum[33] ? '1 : total_sum[32:0];
               pos_ff <= start_ff;
               vel_ff <= '0;
               acc_ff <= '0;
            end
            default: begin
               neg_ff <= neg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            tgt_ff  <= target_position;
            npos_ff <= new_position;
            step_ff <= time_step;
         end
         CMD_TAU: begin
            if (el_ff < ta_ff) begin
               tau_ff <= el_ff;
            end else if ({1'b0, el_ff} < tc) begin
               tau_ff <= el_ff - ta_ff;
            end else begin
               tau_ff <= 32'({1'b0, el_ff} - tc);
            end
         end
         CMD_MA:     ma_ff   <= prod[62:0];
         CMD_MB:     mb_ff   <= prod[62:0];
         CMD_PA_LO:  lo_ff   <= prod;
         CMD_PA_HI:  hi_ff   <= prod[62:0];
         CMD_PA_SUM: pacc_ff <= mul_comb(lo_ff, hi_ff);
         CMD_Q_LO:   lo_ff   <= prod;
         CMD_Q_HI:   hi_ff   <= prod[62:0];
         CMD_Q_SUM:  q_ff    <= mul_comb(lo_ff, hi_ff);
         CMD_CV:     cv_ff   <= prod >> FRAC_BITS;
         CMD_TV:     tv_ff   <= prod >> FRAC_BITS;
         CMD_S1:     s_ff    <= sat_add(pacc_ff, (phase_ff == PH_CRUISE) ? tv_ff : cv_ff);
         CMD_S2: begin
            if (phase_ff == PH_DECEL) begin
               s_ff <= sat_add(s_ff, tv_ff);
            end
         end
         CMD_S3:        p_ff    <= (psel > 64'(d)) ? d : psel[31:0];
         CMD_VV:        num_ff  <= prod;
         CMD_DA:        num_ff  <= prod;
         CMD_DMIN_TAKE: dmin_ff <= quotient;
         CMD_EMIT:      rsp_ff  <= {acc_ff, vel_ff, pos_ff};
         default: begin
            rsp_ff <= rsp_ff;
         end
      endcase
   end

   assign status.tt_zero   = (tt_ff == '0);
   assign status.el_ge_tt  = ({1'b0, el_ff} >= tt_ff);
   assign status.el_zero   = (el_ff == '0);
   assign status.d_zero    = (d == '0);
   assign status.d_ge_dmin = (64'(d) >= dmin_ff);
   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sq_busy;
   assign rsp_data         = rsp_ff;
endmodule

FILE: design/trapezoid_motion_profile_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Content
// req_      in         tuser: action; tdata: target, new position, time step
// rsp_      out        tdata: position, velocity, acceleration
// csr_      in         write enable, register index, write data
//
// A tick advances the elapsed time, then holds the start or goal or computes the new state.
// Set-position and an unused action pass straight to the result.
// A plan runs three 64-step radix-2 divisions, or two when a 32-step square root replaces
// the cruise division; a zero distance skips them.
// Reset is synchronous; it restores the limits to one unit and clears the axis state.
// A request is taken while a result waits; the next result then waits in its last step.
module trapezoid_motion_profile_core #(
   parameter int FRAC_BITS = tmpg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // action
   input  logic [79:0] req_tdata,   // target_position, new_position, time_step
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // position_out, velocity_out, acceleration_out
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [30:0] csr_wdata
);
   import tmpg_pkg::*;

   cmd_type    cmd;
   status_type status;

   tmpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmpg_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .target_position (req_tdata[31:0]),
      .new_position    (req_tdata[63:32]),
      .time_step       (req_tdata[79:64]),
      .rsp_data        (rsp_tdata)
   );
endmodule

FILE: design/tmpg_checker.sv
`timescale 1ns / 1ps
`include "trapezoid_motion_profile_core_macros.svh"
module tmpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic [79:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        csr_we,
   input logic        csr_addr,
   input logic [30:0] csr_wdata
);
   import tmpg_pkg::*;

   `TMPG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TMPG_ASSERT_NEXT(a_busy_after_transfer, req_tvalid && req_tready, !req_tready)
   `TMPG_ASSERT_IMPL(a_setpos_result, $past(req_tvalid && req_tready && !rsp_tvalid && req_tuser == ACT_SETPOS, 3) && !$past(reset, 1) && !$past(reset, 2), rsp_tvalid && rsp_tdata[31:0] == $past(req_tdata[63:32], 3) && rsp_tdata[63:32] == 32'd0)
   `TMPG_ASSERT_IMPL(a_idle_result, $past(req_tvalid && req_tready && !rsp_tvalid && req_tuser == ACT_NONE, 2) && !$past(reset, 1), rsp_tvalid)
endmodule

bind trapezoid_motion_profile_core tmpg_checker u_checker (.*);
